// ===== hdl/deaa_pkg.sv =====
// Shared types and codes of the double-ended arena allocator.
// Used by every module of the block; it depends on nothing else.
package deaa_pkg;

  localparam logic [2:0] OP_ALLOC_LO = 3'd0;
  localparam logic [2:0] OP_ALLOC_HI = 3'd1;
  localparam logic [2:0] OP_SET_LO   = 3'd2;
  localparam logic [2:0] OP_SET_HI   = 3'd3;
  localparam logic [2:0] OP_GET_LO   = 3'd4;
  localparam logic [2:0] OP_GET_HI   = 3'd5;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_NULL = 2'd1;
  localparam logic [1:0] STATUS_ROOM = 2'd2;

  localparam logic [2:0] KIND_NONE      = 3'd0;
  localparam logic [2:0] KIND_BAD_ARENA = 3'd1;
  localparam logic [2:0] KIND_ALLOC_LO  = 3'd2;
  localparam logic [2:0] KIND_ALLOC_HI  = 3'd3;
  localparam logic [2:0] KIND_SET_LO    = 3'd4;
  localparam logic [2:0] KIND_SET_HI    = 3'd5;
  localparam logic [2:0] KIND_GET_LO    = 3'd6;
  localparam logic [2:0] KIND_GET_HI    = 3'd7;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [2:0]  arena;
    logic [31:0] size;
    logic [4:0]  align_shift;
    logic [31:0] new_address;
  } req_t;

  typedef struct packed {
    logic [31:0] address;
    logic [1:0]  status;
  } rsp_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  arena;
    logic [31:0] size;
    logic [4:0]  align_shift;
    logic [31:0] new_address;
  } work_t;

endpackage

// ===== hdl/deaa_front.sv =====
// Request front end: accepts items and classifies them by operation and arena range.
// Depends on deaa_pkg.
module deaa_front #(
  parameter int ARENA_COUNT = 7
) (
  input  logic             req_valid,
  output logic             req_stall,
  input  deaa_pkg::req_t   req,
  input  logic             full,
  output logic             push,
  output deaa_pkg::work_t  push_item
);

  logic arena_ok;

  assign arena_ok  = int'(req.arena) < ARENA_COUNT;
  assign req_stall = full;
  assign push      = req_valid && !full;

  always_comb begin
    push_item.arena       = req.arena;
    push_item.size        = req.size;
    push_item.align_shift = req.align_shift;
    push_item.new_address = req.new_address;
    unique case (req.opcode)
      deaa_pkg::OP_ALLOC_LO: push_item.kind = deaa_pkg::KIND_ALLOC_LO;
      deaa_pkg::OP_ALLOC_HI: push_item.kind = deaa_pkg::KIND_ALLOC_HI;
      deaa_pkg::OP_SET_LO:   push_item.kind = deaa_pkg::KIND_SET_LO;
      deaa_pkg::OP_SET_HI:   push_item.kind = deaa_pkg::KIND_SET_HI;
      deaa_pkg::OP_GET_LO:   push_item.kind = deaa_pkg::KIND_GET_LO;
      deaa_pkg::OP_GET_HI:   push_item.kind = deaa_pkg::KIND_GET_HI;
      default:               push_item.kind = deaa_pkg::KIND_NONE;
    endcase
    if (!arena_ok && push_item.kind != deaa_pkg::KIND_NONE) begin
      push_item.kind = deaa_pkg::KIND_BAD_ARENA;
    end
  end

endmodule

// ===== hdl/deaa_queue.sv =====
// Two-entry queue of classified items between the front end and the execution unit.
// Depends on deaa_pkg.
module deaa_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  deaa_pkg::work_t  push_item,
  output logic             full,
  input  logic             pop,
  output deaa_pkg::work_t  pop_item,
  output logic             empty
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);

  deaa_pkg::work_t entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;
  logic            do_push;
  logic            do_pop;

  assign full     = count == (PW+1)'(DEPTH);
  assign empty    = count == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== hdl/deaa_back.sv =====
// Execution unit: holds the arena pointers, aligns, checks room, updates and answers.
// Depends on deaa_pkg.
module deaa_back #(
  parameter int ARENA_COUNT = 7,
  parameter int ADDR_WIDTH  = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             empty,
  output logic             pop,
  input  deaa_pkg::work_t  pop_item,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output deaa_pkg::rsp_t   rsp
);

  localparam int AIW = (ARENA_COUNT > 1) ? $clog2(ARENA_COUNT) : 1;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ALIGN  = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [ADDR_WIDTH-1:0] low_pointer  [ARENA_COUNT];
  logic [ADDR_WIDTH-1:0] high_pointer [ARENA_COUNT];

  logic [1:0]            state;
  logic [1:0]            state_next;
  deaa_pkg::work_t       work;
  logic [ADDR_WIDTH-1:0] lo;
  logic [ADDR_WIDTH-1:0] hi;
  logic [ADDR_WIDTH-1:0] start;
  logic [ADDR_WIDTH-1:0] start_next;

  logic [AIW-1:0]        idx;
  logic [ADDR_WIDTH-1:0] keep;
  logic [ADDR_WIDTH-1:0] unit_m1;
  logic [ADDR_WIDTH-1:0] size_a;
  logic [ADDR_WIDTH-1:0] newv;
  logic [ADDR_WIDTH-1:0] rd_lo;
  logic [ADDR_WIDTH-1:0] rd_hi;
  logic [ADDR_WIDTH-1:0] end_lo;
  logic [ADDR_WIDTH-1:0] addr_next;
  logic [1:0]            status_next;
  logic                  wr_lo;
  logic                  wr_hi;
  logic [ADDR_WIDTH-1:0] wr_val;
  logic                  slot_free;
  logic                  finish;

  assign idx       = AIW'(work.arena);
  assign keep      = {ADDR_WIDTH{1'b1}} << work.align_shift;
  assign unit_m1   = ~keep;
  assign size_a    = ADDR_WIDTH'(work.size);
  assign newv      = ADDR_WIDTH'(work.new_address);
  assign rd_lo     = low_pointer[idx];
  assign rd_hi     = high_pointer[idx];
  assign end_lo    = (start + size_a + unit_m1) & keep;
  assign slot_free = !rsp_valid || !rsp_stall;
  assign finish    = (state == ST_FINISH) && slot_free;

  always_comb begin
    if (work.kind == deaa_pkg::KIND_ALLOC_HI) begin
      start_next = ((rd_hi & keep) - size_a) & keep;
    end else begin
      start_next = (rd_lo + unit_m1) & keep;
    end
  end

  always_comb begin
    addr_next   = '0;
    status_next = deaa_pkg::STATUS_OK;
    wr_lo       = 1'b0;
    wr_hi       = 1'b0;
    wr_val      = start;
    unique case (work.kind)
      deaa_pkg::KIND_BAD_ARENA: status_next = deaa_pkg::STATUS_NULL;
      deaa_pkg::KIND_ALLOC_LO: begin
        if (lo == '0) begin
          status_next = deaa_pkg::STATUS_NULL;
        end else if (end_lo > hi) begin
          status_next = deaa_pkg::STATUS_ROOM;
        end else begin
          wr_lo     = 1'b1;
          wr_val    = end_lo;
          addr_next = start;
        end
      end
      deaa_pkg::KIND_ALLOC_HI: begin
        if (hi == '0) begin
          status_next = deaa_pkg::STATUS_NULL;
        end else if (start < lo) begin
          status_next = deaa_pkg::STATUS_ROOM;
        end else begin
          wr_hi     = 1'b1;
          addr_next = start;
        end
      end
      deaa_pkg::KIND_SET_LO: begin
        wr_lo  = 1'b1;
        wr_val = newv;
      end
      deaa_pkg::KIND_SET_HI: begin
        wr_hi  = 1'b1;
        wr_val = newv;
      end
      deaa_pkg::KIND_GET_LO: addr_next = lo;
      deaa_pkg::KIND_GET_HI: addr_next = hi;
      default: ;
    endcase
  end

  always_comb begin
    pop        = 1'b0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (!empty) begin
          pop        = 1'b1;
          state_next = ST_ALIGN;
        end
      end
      ST_ALIGN: state_next = ST_FINISH;
      ST_FINISH: begin
        if (slot_free) begin
          pop        = !empty;
          state_next = empty ? ST_IDLE : ST_ALIGN;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (finish) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ARENA_COUNT; i++) begin
        low_pointer[i]  <= '0;
        high_pointer[i] <= '0;
      end
    end else if (finish) begin
      if (wr_lo) begin
        low_pointer[idx] <= wr_val;
      end
      if (wr_hi) begin
        high_pointer[idx] <= wr_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      work <= pop_item;
    end
    if (state == ST_ALIGN) begin
      lo    <= rd_lo;
      hi    <= rd_hi;
      start <= start_next;
    end
    if (finish) begin
      rsp.address <= 32'(addr_next);
      rsp.status  <= status_next;
    end
  end

endmodule

// ===== hdl/double_ended_arena_allocator_top.sv =====
// Top level of the double-ended arena allocator: front end, item queue and execution unit.
// Depends on deaa_pkg, deaa_front, deaa_queue and deaa_back.
//
//   channel   handshake              payload
//   request   req_valid, req_stall   req (deaa_pkg::req_t)
//   response  rsp_valid, rsp_stall   rsp (deaa_pkg::rsp_t)
//
// An item enters the queue at its accepting edge; the execution unit then pops it and
// registers it, registers its arena pointers and aligned start, then the response.
// The execution unit holds one item at a time (ALIGN: pointer read and align, FINISH:
// check and write back); it pops the next as it finishes unless the response stalls.
// Reset clears all arena pointers to zero, empties the queue and drops the response.
// A stalled response holds the execution unit; the queue then fills up to its two entries
// before req_stall rises.
module double_ended_arena_allocator_top #(
  parameter int ARENA_COUNT = 7,
  parameter int ADDR_WIDTH  = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  deaa_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output deaa_pkg::rsp_t  rsp
);

  logic            full;
  logic            empty;
  logic            push;
  logic            pop;
  deaa_pkg::work_t push_item;
  deaa_pkg::work_t pop_item;

  deaa_front #(
    .ARENA_COUNT(ARENA_COUNT)
  ) u_front (
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .full(full),
    .push(push),
    .push_item(push_item)
  );

  deaa_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_item(push_item),
    .full(full),
    .pop(pop),
    .pop_item(pop_item),
    .empty(empty)
  );

  deaa_back #(
    .ARENA_COUNT(ARENA_COUNT),
    .ADDR_WIDTH(ADDR_WIDTH)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .empty(empty),
    .pop(pop),
    .pop_item(pop_item),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

endmodule

// ===== hdl/deaa_checker.sv =====
// Port-level checks of the double-ended arena allocator and their binding to the top level.
// Depends on deaa_pkg and double_ended_arena_allocator_top.
module deaa_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input deaa_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input deaa_pkg::rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("Response item dropped while stalled.");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != deaa_pkg::STATUS_OK |-> rsp.address == '0)
    else $error("Failed item carries a nonzero address.");

  a_reset_rsp: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("Response valid after reset.");

  a_reset_req: assert property (@(posedge clk)
    rst |=> !req_stall)
    else $error("Request stalled right after reset.");

endmodule

bind double_ended_arena_allocator_top deaa_checker u_deaa_checker (.*);

// ===== tb/sv/double_ended_arena_allocator_top_test.sv =====
// Self-checking testbench of the double-ended arena allocator: a queue-fed request driver,
// a response monitor and a predictor of the arena pointers, updated at each accepted request.
// Depends on deaa_pkg and double_ended_arena_allocator_top.
`timescale 1ns / 100ps

module double_ended_arena_allocator_top_test;

  localparam int ARENA_COUNT = 7;
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  deaa_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  deaa_pkg::rsp_t rsp;

  deaa_pkg::req_t pending_requests[$];
  deaa_pkg::rsp_t awaited_results[$];
  logic [31:0] low_ptr[ARENA_COUNT];
  logic [31:0] high_ptr[ARENA_COUNT];
  int unsigned req_offered = 0;
  int unsigned req_accepted = 0;
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;

  double_ended_arena_allocator_top dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always #4 clk = ~clk;

  function automatic deaa_pkg::rsp_t allocator_outcome(deaa_pkg::req_t r);
    deaa_pkg::rsp_t res;
    logic [31:0] unit_m1;
    logic [31:0] keep;
    logic [31:0] start;
    logic [31:0] stop;
    res.address = '0;
    res.status = deaa_pkg::STATUS_OK;
    unit_m1 = (32'd1 << r.align_shift) - 32'd1;
    keep = ~unit_m1;
    if (r.opcode <= deaa_pkg::OP_GET_HI && r.arena >= ARENA_COUNT) begin
      res.status = deaa_pkg::STATUS_NULL;
    end else begin
      case (r.opcode)
        deaa_pkg::OP_ALLOC_LO: begin
          if (low_ptr[r.arena] == '0) begin
            res.status = deaa_pkg::STATUS_NULL;
          end else begin
            start = (low_ptr[r.arena] + unit_m1) & keep;
            stop = (start + r.size + unit_m1) & keep;
            if (stop > high_ptr[r.arena]) begin
              res.status = deaa_pkg::STATUS_ROOM;
            end else begin
              low_ptr[r.arena] = stop;
              res.address = start;
            end
          end
        end
        deaa_pkg::OP_ALLOC_HI: begin
          if (high_ptr[r.arena] == '0) begin
            res.status = deaa_pkg::STATUS_NULL;
          end else begin
            start = ((high_ptr[r.arena] & keep) - r.size) & keep;
            if (start < low_ptr[r.arena]) begin
              res.status = deaa_pkg::STATUS_ROOM;
            end else begin
              high_ptr[r.arena] = start;
              res.address = start;
            end
          end
        end
        deaa_pkg::OP_SET_LO: low_ptr[r.arena] = r.new_address;
        deaa_pkg::OP_SET_HI: high_ptr[r.arena] = r.new_address;
        deaa_pkg::OP_GET_LO: res.address = low_ptr[r.arena];
        deaa_pkg::OP_GET_HI: res.address = high_ptr[r.arena];
        default: ;
      endcase
    end
    return res;
  endfunction

  function automatic deaa_pkg::req_t make_req(logic [2:0] op, logic [2:0] id, logic [31:0] sz,
                                              logic [4:0] sh, logic [31:0] na);
    deaa_pkg::req_t r;
    r.opcode = op;
    r.arena = id;
    r.size = sz;
    r.align_shift = sh;
    r.new_address = na;
    return r;
  endfunction

  task automatic push_req(logic [2:0] op, logic [2:0] id, logic [31:0] sz, logic [4:0] sh,
                          logic [31:0] na);
    pending_requests.push_back(make_req(op, id, sz, sh, na));
  endtask

  task automatic push_session();
    logic [2:0] id;
    logic [31:0] base;
    logic [31:0] span;
    logic [2:0] op;
    logic [31:0] sz;
    logic [4:0] sh;
    int unsigned pick;
    int unsigned n;
    id = 3'($urandom_range(0, ARENA_COUNT - 1));
    pick = $urandom_range(0, 99);
    if (pick < 70) base = $urandom_range(1, 32'h00FF_FFFF);
    else if (pick < 85) base = 32'hFFFF_0000 + $urandom_range(0, 16'hFFFF);
    else base = $urandom;
    span = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 4096));
    pick = $urandom_range(0, 19);
    if (pick != 0) push_req(deaa_pkg::OP_SET_LO, id, $urandom, 5'($urandom), base);
    if (pick != 1) push_req(deaa_pkg::OP_SET_HI, id, $urandom, 5'($urandom), base + span);
    n = $urandom_range(4, 12);
    repeat (n) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) op = deaa_pkg::OP_ALLOC_LO;
      else if (pick < 8) op = deaa_pkg::OP_ALLOC_HI;
      else if (pick == 8) op = deaa_pkg::OP_GET_LO;
      else op = deaa_pkg::OP_GET_HI;
      sz = ($urandom_range(0, 4) == 0) ? $urandom : 32'($urandom_range(0, 300));
      sh = ($urandom_range(0, 6) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 6));
      push_req(op, id, sz, sh, $urandom);
    end
  endtask

  task automatic fill_random(int unsigned target);
    int unsigned start_count;
    start_count = pending_requests.size();
    while (pending_requests.size() - start_count < target) begin
      if ($urandom_range(0, 4) == 0) begin
        push_req(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), $urandom,
                 5'($urandom_range(0, 31)), $urandom);
      end else begin
        push_session();
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || req_accepted != req_offered) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_accepted == req_offered) begin
      if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        req <= pending_requests.pop_front();
        req_valid <= 1'b1;
        req_offered++;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = 60;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    deaa_pkg::rsp_t got;
    deaa_pkg::rsp_t want;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        awaited_results.push_back(allocator_outcome(req));
        req_accepted++;
      end
      if (rsp_valid && !rsp_stall) begin
        got = rsp;
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got address %h status %0d",
                   $time, got.address, got.status);
          mismatch_count++;
        end else begin
          want = awaited_results.pop_front();
          if (got.address !== want.address) begin
            $display("%0t: address mismatch, expected %h, got %h",
                     $time, want.address, got.address);
            mismatch_count++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, got.status);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin
    foreach (low_ptr[i]) begin
      low_ptr[i] = '0;
      high_ptr[i] = '0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    push_req(deaa_pkg::OP_ALLOC_LO, 3'd0, 32'd16, 5'd4, 32'd0);
    push_req(deaa_pkg::OP_ALLOC_HI, 3'd0, 32'd16, 5'd4, 32'd0);
    push_req(deaa_pkg::OP_GET_LO, 3'd0, 32'd0, 5'd0, 32'd0);
    push_req(deaa_pkg::OP_GET_HI, 3'd6, 32'd0, 5'd0, 32'd0);
    push_req(OP_SPARE_A, 3'd0, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF);
    push_req(OP_SPARE_B, 3'd7, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF);
    push_req(deaa_pkg::OP_SET_LO, 3'd7, 32'd0, 5'd0, 32'h0000_1234);
    push_req(deaa_pkg::OP_GET_HI, 3'd7, 32'd0, 5'd0, 32'd0);
    push_req(deaa_pkg::OP_SET_LO, 3'd0, 32'd0, 5'd0, 32'h0000_1001);
    push_req(deaa_pkg::OP_SET_HI, 3'd0, 32'd0, 5'd0, 32'h0000_2000);
    push_req(deaa_pkg::OP_ALLOC_LO, 3'd0, 32'h10, 5'd4, 32'd0);
    push_req(deaa_pkg::OP_ALLOC_HI, 3'd0, 32'h100, 5'd8, 32'd0);
    push_req(deaa_pkg::OP_ALLOC_LO, 3'd0, 32'hFFFF_FFFF, 5'd0, 32'd0);
    push_req(deaa_pkg::OP_ALLOC_LO, 3'd0, 32'h0001_0000, 5'd0, 32'd0);
    push_req(deaa_pkg::OP_ALLOC_HI, 3'd0, 32'h0001_0000, 5'd0, 32'd0);
    push_req(deaa_pkg::OP_GET_LO, 3'd0, 32'd0, 5'd0, 32'd0);
    push_req(deaa_pkg::OP_GET_HI, 3'd0, 32'd0, 5'd0, 32'd0);
    push_req(deaa_pkg::OP_SET_LO, 3'd1, 32'd0, 5'd0, 32'h8000_0001);
    push_req(deaa_pkg::OP_SET_HI, 3'd1, 32'd0, 5'd0, 32'hFFFF_FFFF);
    push_req(deaa_pkg::OP_ALLOC_LO, 3'd1, 32'd1, 5'd31, 32'd0);
    push_req(deaa_pkg::OP_ALLOC_HI, 3'd1, 32'd0, 5'd31, 32'd0);
    push_req(deaa_pkg::OP_SET_HI, 3'd2, 32'd0, 5'd0, 32'hFFFF_FFFF);
    push_req(deaa_pkg::OP_ALLOC_HI, 3'd2, 32'hFFFF_FFFF, 5'd0, 32'd0);
    push_req(deaa_pkg::OP_GET_HI, 3'd2, 32'd0, 5'd0, 32'd0);
    wait_drained();

    send_idle_pct = 27;
    recv_idle_pct = 75;
    fill_random(200);
    wait_drained();

    send_idle_pct = 75;
    recv_idle_pct = 27;
    fill_random(200);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    fill_random(30);
    hold_requests++;
    wait_drained();

    fill_random(200);
    wait_drained();

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/deaa_pkg.sv
hdl/deaa_front.sv
hdl/deaa_queue.sv
hdl/deaa_back.sv
hdl/double_ended_arena_allocator_top.sv
hdl/deaa_checker.sv
tb/sv/double_ended_arena_allocator_top_test.sv
